// ----- design/bcft_pkg.sv -----
// package for the byte credit flow tracker: transaction types, mode and register codes
`timescale 1ns / 1ps

package bcft_pkg;

   // field widths
   localparam int unsigned MODE_WIDTH      = 3;
   localparam int unsigned BYTE_WIDTH      = 32;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   // transaction modes
   localparam logic [MODE_WIDTH-1:0] MODE_ADMIT          = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_CONSUME        = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_TAKE_RETURN    = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_PEEK_RETURN    = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_COMMIT_RETURN  = 3'd4;
   localparam logic [MODE_WIDTH-1:0] MODE_CONSUMER_EPOCH = 3'd5;
   localparam logic [MODE_WIDTH-1:0] MODE_PRODUCER_EPOCH = 3'd6;
   localparam logic [MODE_WIDTH-1:0] MODE_CLEAR          = 3'd7;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAPACITY_BYTES     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RETURN_BATCH_BYTES = 2'd1;

   // register reset values
   localparam logic [BYTE_WIDTH-1:0] CAPACITY_RESET     = 32'd4096;
   localparam logic [BYTE_WIDTH-1:0] RETURN_BATCH_RESET = 32'd1;

   // request transaction
   typedef struct packed {
      logic [MODE_WIDTH-1:0] mode;
      logic [BYTE_WIDTH-1:0] byte_count;
      logic                  force_req;
   } req_type;

   // response transaction
   typedef struct packed {
      logic                  admitted;
      logic [BYTE_WIDTH-1:0] return_bytes;
      logic [BYTE_WIDTH-1:0] outstanding_bytes;
      logic [BYTE_WIDTH-1:0] ring_bytes;
      logic [BYTE_WIDTH-1:0] window_remaining;
      logic [BYTE_WIDTH-1:0] consumed_total;
      logic [BYTE_WIDTH-1:0] violation_count;
      logic [BYTE_WIDTH-1:0] overuse_count;
      logic                  desync_flag;
   } rsp_type;

endpackage

// ----- design/byte_credit_flow_tracker_core.sv -----
// byte credit flow tracker: running totals, admit check, batched credit return
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_ready | bcft_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_ready | bcft_pkg::rsp_type
//   csr     | in        | csr_we              | csr_index, csr_wdata
//
// one transaction per cycle sustained while rsp_ready holds; an accepted req
// goes into the request register, then through one pass of 32-bit add/compare
// logic into the response register. reset clears the totals and counters and
// loads the register defaults. a stalled rsp holds the response register and
// backs up into the request register; req_ready falls only when both are full.
`timescale 1ns / 1ps

module byte_credit_flow_tracker_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  bcft_pkg::req_type                     req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output bcft_pkg::rsp_type                     rsp_payload,
   input  logic                                  csr_we,
   input  logic [bcft_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [bcft_pkg::BYTE_WIDTH-1:0]       csr_wdata
);

   localparam int unsigned W = bcft_pkg::BYTE_WIDTH;

   // pipeline registers
   logic              req_valid_ff, req_valid_in;
   bcft_pkg::req_type req_ff, req_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bcft_pkg::rsp_type rsp_ff, rsp_in;

   // configuration registers
   logic [W-1:0] capacity_ff, capacity_in;
   logic [W-1:0] batch_ff, batch_in;

   // tracker state
   logic [W-1:0] received_ff, received_in;
   logic [W-1:0] consumed_ff, consumed_in;
   logic [W-1:0] returned_ff, returned_in;
   logic [W-1:0] violations_ff, violations_in;
   logic [W-1:0] overuses_ff, overuses_in;
   logic         desync_ff, desync_in;

   logic         advance;
   logic [W-1:0] outst_pre, ring_pre, pend_pre, credit, outst_post;
   logic [W:0]   admit_sum;
   logic         admit_fit, admitted;
   logic [W-1:0] ret_bytes;

   // handshake: the request stage moves when the response register frees up
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // request register load
   always_comb begin
      req_valid_in = req_valid_ff;
      req_in       = req_ff;
      if (req_ready) begin
         req_valid_in = req_valid;
         req_in       = req_payload;
      end
   end

   // configuration writes, zero batch held as one
   always_comb begin
      capacity_in = capacity_ff;
      batch_in    = batch_ff;
      if (csr_we) begin
         if (csr_index == bcft_pkg::CSR_CAPACITY_BYTES) begin
            capacity_in = csr_wdata;
         end else if (csr_index == bcft_pkg::CSR_RETURN_BATCH_BYTES) begin
            batch_in = (csr_wdata == '0) ? W'(1) : csr_wdata;
         end
      end
   end

   // figures from the current totals
   assign outst_pre = received_ff - returned_ff;
   assign ring_pre  = received_ff - consumed_ff;
   assign pend_pre  = consumed_ff - returned_ff;
   assign admit_sum = {1'b0, outst_pre} + {1'b0, req_ff.byte_count};
   assign admit_fit = admit_sum <= {1'b0, capacity_ff};

   // pending credit offered to take and peek
   assign credit = (pend_pre == '0) ? '0 :
                   (!req_ff.force_req && (pend_pre < batch_ff)) ? '0 : pend_pre;

   // state update for one transaction
   always_comb begin
      received_in   = received_ff;
      consumed_in   = consumed_ff;
      returned_in   = returned_ff;
      violations_in = violations_ff;
      overuses_in   = overuses_ff;
      desync_in     = desync_ff;
      admitted      = 1'b0;
      ret_bytes     = '0;
      if (advance) begin
         case (req_ff.mode)
            bcft_pkg::MODE_ADMIT: begin
               if (admit_fit) begin
                  received_in = received_ff + req_ff.byte_count;
                  admitted    = 1'b1;
               end else begin
                  violations_in = violations_ff + W'(1);
                  desync_in     = 1'b1;
               end
            end
            bcft_pkg::MODE_CONSUME: begin
               if (req_ff.byte_count > ring_pre) begin
                  overuses_in = overuses_ff + W'(1);
                  consumed_in = received_ff;
               end else begin
                  consumed_in = consumed_ff + req_ff.byte_count;
               end
            end
            bcft_pkg::MODE_TAKE_RETURN: begin
               ret_bytes   = credit;
               returned_in = returned_ff + credit;
            end
            bcft_pkg::MODE_PEEK_RETURN: begin
               ret_bytes = credit;
            end
            bcft_pkg::MODE_COMMIT_RETURN: begin
               if (req_ff.byte_count > pend_pre) begin
                  returned_in = consumed_ff;
               end else begin
                  returned_in = returned_ff + req_ff.byte_count;
               end
            end
            bcft_pkg::MODE_CONSUMER_EPOCH: begin
               consumed_in = '0;
               returned_in = '0;
               desync_in   = 1'b0;
            end
            bcft_pkg::MODE_PRODUCER_EPOCH: begin
               received_in = '0;
            end
            default: begin
               received_in = '0;
               consumed_in = '0;
               returned_in = '0;
               desync_in   = 1'b0;
            end
         endcase
      end
   end

   // response built from the updated totals
   assign outst_post = received_in - returned_in;
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in              = 1'b1;
         rsp_in.admitted           = admitted;
         rsp_in.return_bytes       = ret_bytes;
         rsp_in.outstanding_bytes  = outst_post;
         rsp_in.ring_bytes         = received_in - consumed_in;
         rsp_in.window_remaining   = (outst_post >= capacity_ff) ? '0
                                     : capacity_ff - outst_post;
         rsp_in.consumed_total     = consumed_in;
         rsp_in.violation_count    = violations_in;
         rsp_in.overuse_count      = overuses_in;
         rsp_in.desync_flag        = desync_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         capacity_ff   <= bcft_pkg::CAPACITY_RESET;
         batch_ff      <= bcft_pkg::RETURN_BATCH_RESET;
         received_ff   <= '0;
         consumed_ff   <= '0;
         returned_ff   <= '0;
         violations_ff <= '0;
         overuses_ff   <= '0;
         desync_ff     <= 1'b0;
      end else begin
         req_valid_ff  <= req_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         capacity_ff   <= capacity_in;
         batch_ff      <= batch_in;
         received_ff   <= received_in;
         consumed_ff   <= consumed_in;
         returned_ff   <= returned_in;
         violations_ff <= violations_in;
         overuses_ff   <= overuses_in;
         desync_ff     <= desync_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   // a transaction that moves always lands in the response register
   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("response register not loaded after advance");

   // counters only move with a transaction
   a_counters_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(violations_ff) && $stable(overuses_ff) && $stable(received_ff))
      else $error("tracker state changed without a transaction");

   // clear zeroes the totals and drops desync
   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      advance && (req_ff.mode == bcft_pkg::MODE_CLEAR)
      |=> (received_ff == '0) && (consumed_ff == '0) && (returned_ff == '0) && !desync_ff)
      else $error("clear left state behind");

   // an admitted transaction never reports returned credit
   a_admit_no_return: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.admitted |-> (rsp_ff.return_bytes == '0))
      else $error("admit reported return bytes");

   // batch register never holds zero
   a_batch_nonzero: assert property (@(posedge clock) disable iff (reset)
      batch_ff != '0)
      else $error("return batch register is zero");

endmodule

// ----- test/bcft_credit_checker.sv -----
// credit tracker checker: watches the req, rsp and csr ports, predicts each response and compares
`timescale 1ns / 1ps

module bcft_credit_checker
   import bcft_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  req_type                    req_payload,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  rsp_type                    rsp_payload,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [BYTE_WIDTH-1:0]      csr_wdata,
   output int unsigned                results_awaited,
   output int unsigned                mismatch_total
);

   // keep the log short when the block is badly broken
   localparam int unsigned PRINT_LIMIT = 150;

   // shadow registers and running totals
   logic [BYTE_WIDTH-1:0] window_capacity;
   logic [BYTE_WIDTH-1:0] batch_threshold;
   logic [BYTE_WIDTH-1:0] received_bytes;
   logic [BYTE_WIDTH-1:0] consumed_bytes;
   logic [BYTE_WIDTH-1:0] returned_bytes;
   logic [BYTE_WIDTH-1:0] refused_admits;
   logic [BYTE_WIDTH-1:0] overrun_consumes;
   logic                  desync_seen;

   // predicted responses, oldest first
   rsp_type expected_status[$];

   task automatic report_mismatch(input string note);
      mismatch_total = mismatch_total + 1;
      if (mismatch_total <= PRINT_LIMIT) begin
         $display("%0t mismatch: %s", $time, note);
      end
   endtask

   task automatic check_field(input string field, input logic [BYTE_WIDTH-1:0] seen,
                              input logic [BYTE_WIDTH-1:0] wanted);
      if (seen !== wanted) begin
         report_mismatch($sformatf("%s got %h expected %h", field, seen, wanted));
      end
   endtask

   // credit that a take or peek hands back right now
   function automatic logic [BYTE_WIDTH-1:0] releasable_credit(input logic force_now);
      logic [BYTE_WIDTH-1:0] owed;
      owed = consumed_bytes - returned_bytes;
      if (owed == '0) return '0;
      if (!force_now && owed < batch_threshold) return '0;
      return owed;
   endfunction

   // apply one transaction to the totals and build the status it reports
   function automatic rsp_type predict_credit_status(input req_type item);
      rsp_type               status;
      logic [BYTE_WIDTH:0]   fit_total;
      logic [BYTE_WIDTH-1:0] amount;
      logic [BYTE_WIDTH-1:0] in_ring;
      logic [BYTE_WIDTH-1:0] owed;
      logic [BYTE_WIDTH-1:0] in_flight;
      status = '0;
      amount = item.byte_count;
      case (item.mode)
         MODE_ADMIT: begin
            // fit test is done one bit wider so it never wraps
            fit_total = {1'b0, received_bytes - returned_bytes} + {1'b0, amount};
            if (fit_total > {1'b0, window_capacity}) begin
               refused_admits = refused_admits + BYTE_WIDTH'(1);
               desync_seen = 1'b1;
            end else begin
               received_bytes = received_bytes + amount;
               status.admitted = 1'b1;
            end
         end
         MODE_CONSUME: begin
            in_ring = received_bytes - consumed_bytes;
            if (amount > in_ring) begin
               overrun_consumes = overrun_consumes + BYTE_WIDTH'(1);
               amount = in_ring;
            end
            consumed_bytes = consumed_bytes + amount;
         end
         MODE_TAKE_RETURN: begin
            status.return_bytes = releasable_credit(item.force_req);
            returned_bytes = returned_bytes + status.return_bytes;
         end
         MODE_PEEK_RETURN: begin
            status.return_bytes = releasable_credit(item.force_req);
         end
         MODE_COMMIT_RETURN: begin
            owed = consumed_bytes - returned_bytes;
            if (amount > owed) amount = owed;
            returned_bytes = returned_bytes + amount;
         end
         MODE_CONSUMER_EPOCH: begin
            consumed_bytes = '0;
            returned_bytes = '0;
            desync_seen = 1'b0;
         end
         MODE_PRODUCER_EPOCH: begin
            received_bytes = '0;
         end
         default: begin
            received_bytes = '0;
            consumed_bytes = '0;
            returned_bytes = '0;
            desync_seen = 1'b0;
         end
      endcase
      in_flight = received_bytes - returned_bytes;
      status.outstanding_bytes = in_flight;
      status.ring_bytes = received_bytes - consumed_bytes;
      status.window_remaining = (in_flight >= window_capacity) ? '0
                                                               : window_capacity - in_flight;
      status.consumed_total = consumed_bytes;
      status.violation_count = refused_admits;
      status.overuse_count = overrun_consumes;
      status.desync_flag = desync_seen;
      return status;
   endfunction

   // sample every port at the rising edge
   always @(posedge clock) begin : watch
      rsp_type wanted;
      if (reset) begin
         window_capacity = CAPACITY_RESET;
         batch_threshold = RETURN_BATCH_RESET;
         received_bytes = '0;
         consumed_bytes = '0;
         returned_bytes = '0;
         refused_admits = '0;
         overrun_consumes = '0;
         desync_seen = 1'b0;
         expected_status.delete();
      end else begin
         // register writes; unmapped indexes are dropped
         if (csr_we) begin
            case (csr_index)
               CSR_CAPACITY_BYTES:     window_capacity = csr_wdata;
               CSR_RETURN_BATCH_BYTES: batch_threshold = (csr_wdata == '0) ? 32'd1 : csr_wdata;
               default: ;
            endcase
         end
         // response side
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               report_mismatch("response with no transaction waiting");
            end else begin
               wanted = expected_status.pop_front();
               check_field("admitted", BYTE_WIDTH'(rsp_payload.admitted),
                           BYTE_WIDTH'(wanted.admitted));
               check_field("return_bytes", rsp_payload.return_bytes, wanted.return_bytes);
               check_field("outstanding_bytes", rsp_payload.outstanding_bytes,
                           wanted.outstanding_bytes);
               check_field("ring_bytes", rsp_payload.ring_bytes, wanted.ring_bytes);
               check_field("window_remaining", rsp_payload.window_remaining,
                           wanted.window_remaining);
               check_field("consumed_total", rsp_payload.consumed_total, wanted.consumed_total);
               check_field("violation_count", rsp_payload.violation_count,
                           wanted.violation_count);
               check_field("overuse_count", rsp_payload.overuse_count, wanted.overuse_count);
               check_field("desync_flag", BYTE_WIDTH'(rsp_payload.desync_flag),
                           BYTE_WIDTH'(wanted.desync_flag));
            end
         end
         // request side
         if (req_valid && req_ready) begin
            expected_status.push_back(predict_credit_status(req_payload));
         end
      end
      results_awaited <= expected_status.size();
   end

endmodule

// ----- test/byte_credit_flow_tracker_core_test.sv -----
// testbench top for the byte credit flow tracker: clock, reset, stimulus, idling and verdict
`timescale 1ns / 1ps

module byte_credit_flow_tracker_core_test;
   import bcft_pkg::*;

   localparam int unsigned IDLE_LIMIT    = 2000;
   localparam int unsigned PHASE_COUNT   = 8;
   localparam int unsigned PHASE_ITEMS   = 100;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED = 2'd3;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_type                    req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_type                    rsp_payload;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [BYTE_WIDTH-1:0]      csr_wdata = '0;

   // idling switches and the credit window that sizes random counts
   bit                         req_gaps_on = 1'b0;
   bit                         rsp_stalls_on = 1'b0;
   logic [BYTE_WIDTH-1:0]      window_size = CAPACITY_RESET;

   int unsigned                results_awaited;
   int unsigned                mismatch_total;

   byte_credit_flow_tracker_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   bcft_credit_checker credit_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .results_awaited (results_awaited),
      .mismatch_total  (mismatch_total)
   );

   always #6 clock = ~clock;

   // offer one transaction and hold it until accepted
   task automatic send_transaction(input logic [MODE_WIDTH-1:0] mode,
                                   input logic [BYTE_WIDTH-1:0] count,
                                   input logic                  force_flag);
      req_type item;
      item.mode = mode;
      item.byte_count = count;
      item.force_req = force_flag;
      if (req_gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop sending until every response is back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_awaited != 0);
   endtask

   // both registers, then a write to an unmapped index that must be dropped
   task automatic write_config(input logic [BYTE_WIDTH-1:0] capacity,
                               input logic [BYTE_WIDTH-1:0] batch);
      csr_we <= 1'b1;
      csr_index <= CSR_CAPACITY_BYTES;
      csr_wdata <= capacity;
      @(posedge clock);
      csr_index <= CSR_RETURN_BATCH_BYTES;
      csr_wdata <= batch;
      @(posedge clock);
      csr_index <= CSR_UNMAPPED;
      csr_wdata <= $urandom();
      @(posedge clock);
      csr_we <= 1'b0;
      window_size = capacity;
   endtask

   // admits and consumes dominate, epochs and clears are rare
   function automatic logic [MODE_WIDTH-1:0] pick_mode();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) return MODE_ADMIT;
      if (roll < 55) return MODE_CONSUME;
      if (roll < 67) return MODE_TAKE_RETURN;
      if (roll < 75) return MODE_PEEK_RETURN;
      if (roll < 88) return MODE_COMMIT_RETURN;
      if (roll < 92) return MODE_CONSUMER_EPOCH;
      if (roll < 96) return MODE_PRODUCER_EPOCH;
      return MODE_CLEAR;
   endfunction

   // counts mostly scaled to the window so admits often fit
   function automatic logic [BYTE_WIDTH-1:0] pick_byte_count(input logic [BYTE_WIDTH-1:0] window);
      logic [BYTE_WIDTH-1:0] span;
      span = (window < 32) ? 32'd8 : window / 4;
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return $urandom();
         3: return window;
         default: return $urandom_range(0, span);
      endcase
   endfunction

   // response side backpressure
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // watchdog on cycles with no transaction on either channel
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles = idle_cycles + 1;
      end
      $display("status: fail");
      $finish;
   end

   // main sequence
   initial begin
      logic [BYTE_WIDTH-1:0] capacity;
      logic [BYTE_WIDTH-1:0] batch;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset window: exact fit, refusal, overuse clamp, returns, epochs
      send_transaction(MODE_ADMIT, 32'd0, 1'b0);
      send_transaction(MODE_ADMIT, 32'd4096, 1'b1);
      send_transaction(MODE_ADMIT, 32'd1, 1'b0);
      send_transaction(MODE_CONSUME, 32'hFFFF_FFFF, 1'b1);
      send_transaction(MODE_PEEK_RETURN, 32'hA5A5_5A5A, 1'b0);
      send_transaction(MODE_COMMIT_RETURN, 32'd100, 1'b1);
      send_transaction(MODE_TAKE_RETURN, 32'h5A5A_A5A5, 1'b0);
      send_transaction(MODE_TAKE_RETURN, 32'd0, 1'b1);
      send_transaction(MODE_COMMIT_RETURN, 32'hFFFF_FFFF, 1'b0);
      send_transaction(MODE_CONSUMER_EPOCH, 32'hFFFF_FFFF, 1'b1);
      send_transaction(MODE_PRODUCER_EPOCH, 32'h1234_5678, 1'b0);
      send_transaction(MODE_ADMIT, 32'hFFFF_FFFF, 1'b0);
      send_transaction(MODE_CLEAR, 32'hFFFF_FFFF, 1'b1);
      drain_results();

      // widest window, large batch: admit without wrap, threshold and force
      write_config(32'hFFFF_FFFF, 32'd1000);
      send_transaction(MODE_ADMIT, 32'hFFFF_FFFF, 1'b0);
      send_transaction(MODE_ADMIT, 32'd1, 1'b0);
      send_transaction(MODE_CONSUME, 32'd999, 1'b0);
      send_transaction(MODE_PEEK_RETURN, 32'd0, 1'b0);
      send_transaction(MODE_TAKE_RETURN, 32'd0, 1'b0);
      send_transaction(MODE_PEEK_RETURN, 32'd0, 1'b1);
      send_transaction(MODE_TAKE_RETURN, 32'd0, 1'b1);
      send_transaction(MODE_CONSUMER_EPOCH, 32'd0, 1'b0);
      send_transaction(MODE_PRODUCER_EPOCH, 32'd0, 1'b1);
      send_transaction(MODE_CLEAR, 32'd0, 1'b0);
      drain_results();

      // random phases, each under its own window and batch
      for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin capacity = 32'd4096;       batch = 32'd1;           end
            1: begin capacity = 32'd64;         batch = 32'd16;          end
            2: begin capacity = 32'd0;          batch = 32'd0;           end
            3: begin capacity = 32'd1;          batch = 32'd1;           end
            4: begin capacity = 32'h8000_0000;  batch = 32'hFFFF_FFFF;   end
            5: begin capacity = 32'hFFFF_FFFF;  batch = 32'd1000;        end
            6: begin
               capacity = $urandom_range(16, 100000);
               batch = $urandom_range(1, 512);
            end
            default: begin capacity = 32'd4096; batch = 32'd64;          end
         endcase
         write_config(capacity, batch);
         // no idling at all in the last phase
         req_gaps_on = (phase % 3 != 2) && (phase != PHASE_COUNT - 1);
         rsp_stalls_on = (phase % 3 != 1) && (phase != PHASE_COUNT - 1);
         for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
            send_transaction(pick_mode(), pick_byte_count(window_size),
                             1'($urandom_range(0, 1)));
         end
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_total == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
